/* hdl/src_pkg.sv */
// ----------------------------------------------------------------------------
// src_pkg: shared types and constants for sensor reading compensation
// Request/response structs, calibration register set, pipeline constants.
// ----------------------------------------------------------------------------
`default_nettype none

package src_pkg;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 64;
   localparam int DivSteps = 64;
   // register stages from request capture to response register
   localparam int PipeDepth = 82;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_CAL_TEMP    = 3'd0,
      CSR_CAL_PRESS_A = 3'd1,
      CSR_CAL_PRESS_B = 3'd2,
      CSR_CAL_PRESS_C = 3'd3,
      CSR_CAL_HUM     = 3'd4
   } csr_idx_type;

   localparam logic [20:0]        PressBase   = 21'd1048576;
   localparam logic signed [32:0] FineOffP    = 33'sd128000;
   localparam logic [11:0]        PressScale  = 12'd3125;
   localparam logic [63:0]        PressBias   = 64'h0000_8000_0000_0000;
   localparam logic [31:0]        FineOffH    = 32'd76800;
   localparam logic [31:0]        HumRound    = 32'd16384;
   localparam logic [31:0]        HumOffset   = 32'd32768;
   localparam logic [31:0]        HumBias     = 32'd2097152;
   localparam logic [31:0]        HumRound2   = 32'd8192;
   localparam logic [31:0]        HumMax      = 32'd419430400;
   localparam logic [31:0]        TempRound   = 32'd128;

   typedef struct packed {
      logic [19:0] raw_temp;
      logic [19:0] raw_press;
      logic [15:0] raw_hum;
   } req_type;

   typedef struct packed {
      logic signed [23:0] temperature;
      logic [31:0]        pressure;
      logic [16:0]        humidity;
   } rsp_type;

   typedef struct packed {
      logic [47:0] temp;
      logic [63:0] press_a;
      logic [63:0] press_b;
      logic [15:0] press_c;
      logic [63:0] hum;
   } cal_type;

   // temperature stage output, feeds pressure and humidity paths
   typedef struct packed {
      logic               valid;
      logic [31:0]        fine;
      logic signed [23:0] temperature;
      logic [20:0]        press_code;
      logic [15:0]        raw_hum;
   } meas_type;

   // pressure operands ready for the divider
   typedef struct packed {
      logic               valid;
      logic               neg;
      logic               zero;
      logic signed [23:0] temperature;
      logic [63:0]        num;
      logic [63:0]        den;
   } pdiv_type;

   // side data riding along the divider
   typedef struct packed {
      logic               neg;
      logic               zero;
      logic signed [23:0] temperature;
      logic [16:0]        humidity;
   } div_tag_type;

endpackage

`default_nettype wire

/* hdl/src_temp.sv */
// ----------------------------------------------------------------------------
// src_temp: temperature compensation stages
// Five register stages producing the fine value and the 0.01 degC reading.
// ----------------------------------------------------------------------------
`default_nettype none

module src_temp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire src_pkg::req_type in_req,
   input  wire src_pkg::cal_type cal,
   output src_pkg::meas_type     meas
);
   import src_pkg::*;

   logic [31:0] t1, t2, t3;
   logic [4:0]  valid_ff, valid_in;
   logic [31:0] apre_ff, apre_in, dlt_ff, dlt_in;
   logic [31:0] pa_ff, pa_in, dd_ff, dd_in;
   logic [31:0] a_ff, a_in, bb_ff, bb_in;
   logic [31:0] fine_ff, fine_in, fine_d_ff;
   logic [31:0] dsh, bsh, f5, fsh;
   logic signed [23:0] temp_ff, temp_in;
   logic [20:0] pcode_ff [5];
   logic [15:0] hraw_ff [5];

   assign t1 = {16'b0, cal.temp[15:0]};
   assign t2 = {{16{cal.temp[31]}}, cal.temp[31:16]};
   assign t3 = {{16{cal.temp[47]}}, cal.temp[47:32]};

   always_comb begin
      valid_in = {valid_ff[3:0], in_valid};
      apre_in  = {15'b0, in_req.raw_temp[19:3]} - {t1[30:0], 1'b0};
      dlt_in   = {16'b0, in_req.raw_temp[19:4]} - t1;
      pa_in    = apre_ff * t2;
      dd_in    = dlt_ff * dlt_ff;
      a_in     = $signed(pa_ff) >>> 11;
      dsh      = $signed(dd_ff) >>> 12;
      bb_in    = dsh * t3;
      bsh      = $signed(bb_ff) >>> 14;
      fine_in  = a_ff + bsh;
      f5       = fine_ff * 32'd5 + TempRound;
      fsh      = $signed(f5) >>> 8;
      temp_in  = fsh[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      apre_ff     <= apre_in;
      dlt_ff      <= dlt_in;
      pa_ff       <= pa_in;
      dd_ff       <= dd_in;
      a_ff        <= a_in;
      bb_ff       <= bb_in;
      fine_ff     <= fine_in;
      fine_d_ff   <= fine_ff;
      temp_ff     <= temp_in;
      pcode_ff[0] <= PressBase - {1'b0, in_req.raw_press};
      hraw_ff[0]  <= in_req.raw_hum;
      for (int i = 1; i < 5; i++) begin
         pcode_ff[i] <= pcode_ff[i-1];
         hraw_ff[i]  <= hraw_ff[i-1];
      end
   end

   assign meas.valid       = valid_ff[4];
   assign meas.fine        = fine_d_ff;
   assign meas.temperature = temp_ff;
   assign meas.press_code  = pcode_ff[4];
   assign meas.raw_hum     = hraw_ff[4];

endmodule

`default_nettype wire

/* hdl/src_hum.sv */
// ----------------------------------------------------------------------------
// src_hum: humidity compensation stages
// Seven stages of 32-bit multiplies, ending in the final clamp and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module src_hum (
   input  wire logic              clock,
   input  wire src_pkg::meas_type meas,
   input  wire src_pkg::cal_type  cal,
   output logic [16:0]            humidity
);
   import src_pkg::*;

   logic [31:0] h1, h2, h3, h4, h5, h6;
   logic [31:0] hx, hsum, hbsh, hb3sh, hb0sh, hbr, hbrsh, xxsh, hqqsh, tsh, xf, xc;
   logic [31:0] h5x_ff, h5x_in, xh6_ff, xh6_in, xh3_ff, xh3_in;
   logic [31:0] ha_ff, ha_in, hb0_ff, hb0_in, ha2_ff;
   logic [31:0] hbm_ff, hbm_in, xx_ff, xx_in, hqq_ff, hqq_in, t_ff, t_in;
   logic [31:0] xx2_ff, xx3_ff;
   logic [15:0] adh_ff;
   logic [16:0] hum_ff, hum_in;

   assign h1 = {24'b0, cal.hum[7:0]};
   assign h2 = {{16{cal.hum[23]}}, cal.hum[23:8]};
   assign h3 = {24'b0, cal.hum[31:24]};
   assign h4 = {{20{cal.hum[43]}}, cal.hum[43:32]};
   assign h5 = {{20{cal.hum[55]}}, cal.hum[55:44]};
   assign h6 = {{24{cal.hum[63]}}, cal.hum[63:56]};

   always_comb begin
      hx     = meas.fine - FineOffH;
      h5x_in = h5 * hx;
      xh6_in = hx * h6;
      xh3_in = hx * h3;
      hsum   = {2'b0, adh_ff, 14'b0} - {h4[11:0], 20'b0} - h5x_ff + HumRound;
      ha_in  = $signed(hsum) >>> 15;
      hbsh   = $signed(xh6_ff) >>> 10;
      hb3sh  = $signed(xh3_ff) >>> 11;
      hb0_in = hbsh * (hb3sh + HumOffset);
      hb0sh  = $signed(hb0_ff) >>> 10;
      hbm_in = (hb0sh + HumBias) * h2;
      hbr    = hbm_ff + HumRound2;
      hbrsh  = $signed(hbr) >>> 14;
      xx_in  = ha2_ff * hbrsh;
      xxsh   = $signed(xx_ff) >>> 15;
      hqq_in = xxsh * xxsh;
      hqqsh  = $signed(hqq_ff) >>> 7;
      t_in   = hqqsh * h1;
      tsh    = $signed(t_ff) >>> 4;
      xf     = xx3_ff - tsh;
      if (xf[31]) begin
         xc = '0;
      end else if (xf > HumMax) begin
         xc = HumMax;
      end else begin
         xc = xf;
      end
      hum_in = xc[28:12];
   end

   always_ff @(posedge clock) begin
      h5x_ff <= h5x_in;
      xh6_ff <= xh6_in;
      xh3_ff <= xh3_in;
      adh_ff <= meas.raw_hum;
      ha_ff  <= ha_in;
      hb0_ff <= hb0_in;
      ha2_ff <= ha_ff;
      hbm_ff <= hbm_in;
      xx_ff  <= xx_in;
      hqq_ff <= hqq_in;
      xx2_ff <= xx_ff;
      t_ff   <= t_in;
      xx3_ff <= xx2_ff;
      hum_ff <= hum_in;
   end

   assign humidity = hum_ff;

endmodule

`default_nettype wire

/* hdl/src_pprep.sv */
// ----------------------------------------------------------------------------
// src_pprep: pressure operand stages
// Seven stages building the 64-bit dividend and divisor magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module src_pprep (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire src_pkg::meas_type meas,
   input  wire src_pkg::cal_type  cal,
   output src_pkg::pdiv_type      pdiv
);
   import src_pkg::*;

   logic [15:0] p1;
   logic signed [15:0] p2, p3, p4, p5, p6;
   logic [31:0] p3x, p6x;
   logic [6:0] valid_ff, valid_in;

   logic signed [32:0] v1, sq_lo;
   logic signed [65:0] sq_full;
   logic [63:0] sq_ff, sq_in;
   logic signed [48:0] m2_ff [3], m5_ff [3], m2_in, m5_in;
   logic signed [48:0] lo3_ff, lo3_in, lo6_ff, lo6_in;
   logic [31:0] hi3_ff, hi3_in, hi6_ff, hi6_in;
   logic [63:0] s3_ff, s3_in, s6_ff, s6_in;
   logic [63:0] m2x, m5x, s3sh, v2_ff, v2_in, vb_ff, vb_in, nb;
   logic [43:0] nlo_ff, nlo_in;
   logic [47:0] dlo_ff, dlo_in;
   logic [31:0] nhi_ff, nhi_in, dhi_ff, dhi_in;
   logic [63:0] num_ff, num_in, den_ff, den_in, dsum;
   logic [63:0] onum_ff, oden_ff;
   logic neg_ff, zero_ff;
   logic [20:0] pc_ff [4];
   logic signed [23:0] temp_ff [7];

   assign p1 = cal.press_a[15:0];
   assign p2 = $signed(cal.press_a[31:16]);
   assign p3 = $signed(cal.press_a[47:32]);
   assign p4 = $signed(cal.press_a[63:48]);
   assign p5 = $signed(cal.press_b[15:0]);
   assign p6 = $signed(cal.press_b[31:16]);
   assign p3x = {{16{p3[15]}}, p3};
   assign p6x = {{16{p6[15]}}, p6};

   always_comb begin
      valid_in = {valid_ff[5:0], meas.valid};
      // fine - 128000 as a signed 33-bit value
      v1      = $signed({meas.fine[31], meas.fine}) - FineOffP;
      sq_full = v1 * v1;
      sq_in   = sq_full[63:0];
      m2_in   = v1 * p2;
      m5_in   = v1 * p5;
      // low 64 bits of sq * p3 and sq * p6 from 32-bit halves
      sq_lo   = $signed({1'b0, sq_ff[31:0]});
      lo3_in  = sq_lo * p3;
      lo6_in  = sq_lo * p6;
      hi3_in  = sq_ff[63:32] * p3x;
      hi6_in  = sq_ff[63:32] * p6x;
      s3_in   = {{15{lo3_ff[48]}}, lo3_ff} + {hi3_ff, 32'b0};
      s6_in   = {{15{lo6_ff[48]}}, lo6_ff} + {hi6_ff, 32'b0};
      m2x     = {{15{m2_ff[2][48]}}, m2_ff[2]};
      m5x     = {{15{m5_ff[2][48]}}, m5_ff[2]};
      v2_in   = s6_ff + {m5x[46:0], 17'b0} + {{13{p4[15]}}, p4, 35'b0};
      s3sh    = $signed(s3_ff) >>> 8;
      vb_in   = PressBias + s3sh + {m2x[51:0], 12'b0};
      nb      = {12'b0, pc_ff[3], 31'b0} - v2_ff;
      nlo_in  = nb[31:0] * PressScale;
      nhi_in  = nb[63:32] * {20'b0, PressScale};
      dlo_in  = vb_ff[31:0] * p1;
      dhi_in  = vb_ff[63:32] * {16'b0, p1};
      num_in  = {20'b0, nlo_ff} + {nhi_ff, 32'b0};
      dsum    = {16'b0, dlo_ff} + {dhi_ff, 32'b0};
      den_in  = $signed(dsum) >>> 33;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff    <= sq_in;
      m2_ff[0] <= m2_in;
      m5_ff[0] <= m5_in;
      for (int i = 1; i < 3; i++) begin
         m2_ff[i] <= m2_ff[i-1];
         m5_ff[i] <= m5_ff[i-1];
      end
      lo3_ff  <= lo3_in;
      lo6_ff  <= lo6_in;
      hi3_ff  <= hi3_in;
      hi6_ff  <= hi6_in;
      s3_ff   <= s3_in;
      s6_ff   <= s6_in;
      v2_ff   <= v2_in;
      vb_ff   <= vb_in;
      nlo_ff  <= nlo_in;
      nhi_ff  <= nhi_in;
      dlo_ff  <= dlo_in;
      dhi_ff  <= dhi_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      neg_ff  <= num_ff[63] ^ den_ff[63];
      zero_ff <= (den_ff == '0);
      onum_ff <= num_ff[63] ? (64'd0 - num_ff) : num_ff;
      oden_ff <= den_ff[63] ? (64'd0 - den_ff) : den_ff;
      pc_ff[0]   <= meas.press_code;
      temp_ff[0] <= meas.temperature;
      for (int i = 1; i < 4; i++) begin
         pc_ff[i] <= pc_ff[i-1];
      end
      for (int i = 1; i < 7; i++) begin
         temp_ff[i] <= temp_ff[i-1];
      end
   end

   assign pdiv.valid       = valid_ff[6];
   assign pdiv.neg         = neg_ff;
   assign pdiv.zero        = zero_ff;
   assign pdiv.temperature = temp_ff[6];
   assign pdiv.num         = onum_ff;
   assign pdiv.den         = oden_ff;

endmodule

`default_nettype wire

/* hdl/src_div.sv */
// ----------------------------------------------------------------------------
// src_div: pipelined unsigned 64/64 divider
// Restoring division, one quotient bit per register stage, side data carried.
// ----------------------------------------------------------------------------
`default_nettype none

module src_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [63:0]          in_num,
   input  wire logic [63:0]          in_den,
   input  wire src_pkg::div_tag_type in_tag,
   output logic                      out_valid,
   output logic [63:0]               out_quo,
   output src_pkg::div_tag_type      out_tag
);
   import src_pkg::*;

   logic [DivSteps-1:0] valid_ff;
   logic [63:0] rem_ff [DivSteps];
   logic [63:0] quo_ff [DivSteps];
   logic [63:0] den_ff [DivSteps];
   div_tag_type tag_ff [DivSteps];

   for (genvar g = 0; g < DivSteps; g++) begin : g_step
      logic [63:0] rem_src, quo_src, den_src, sh, rem_in, quo_in;
      logic [64:0] diff;
      logic        vld_src;
      div_tag_type tag_src;

      if (g == 0) begin : g_first
         assign rem_src = '0;
         assign quo_src = in_num;
         assign den_src = in_den;
         assign vld_src = in_valid;
         assign tag_src = in_tag;
      end else begin : g_next
         assign rem_src = rem_ff[g-1];
         assign quo_src = quo_ff[g-1];
         assign den_src = den_ff[g-1];
         assign vld_src = valid_ff[g-1];
         assign tag_src = tag_ff[g-1];
      end

      // remainder stays below the divisor, so the shifted value fits 64 bits
      assign sh     = {rem_src[62:0], quo_src[63]};
      assign diff   = {1'b0, sh} - {1'b0, den_src};
      assign rem_in = diff[64] ? sh : diff[63:0];
      assign quo_in = {quo_src[62:0], ~diff[64]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[g] <= rem_in;
         quo_ff[g] <= quo_in;
         den_ff[g] <= den_src;
         tag_ff[g] <= tag_src;
      end
   end

   assign out_valid = valid_ff[DivSteps-1];
   assign out_quo   = quo_ff[DivSteps-1];
   assign out_tag   = tag_ff[DivSteps-1];

endmodule

`default_nettype wire

/* hdl/src_ppost.sv */
// ----------------------------------------------------------------------------
// src_ppost: pressure correction stages after the divide
// Six stages: sign fix, p9 and p8 terms, sum, final shift and p7 offset.
// ----------------------------------------------------------------------------
`default_nettype none

module src_ppost (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [63:0]          in_quo,
   input  wire src_pkg::div_tag_type in_tag,
   input  wire src_pkg::cal_type     cal,
   output logic                      rsp_valid,
   output src_pkg::rsp_type          rsp
);
   import src_pkg::*;

   logic signed [15:0] p7, p8, p9;
   logic [31:0] p8x, p9x;
   logic [5:0]  valid_ff, valid_in;
   div_tag_type tag_ff [5];

   logic [63:0] p_ff [4];
   logic [63:0] p_in, a13, aa_ff, aa_in, v2_ff [2], v2_in, v2s, v1s, v1, sum_ff, sum_in;
   logic [63:0] prs, pr;
   logic [63:0] ll_ff, ll_in;
   logic [31:0] lh_ff, lh_in, ph8_ff, ph8_in, ah9_ff, ah9_in;
   logic signed [48:0] pl8_ff, pl8_in, al9_ff, al9_in;
   rsp_type rsp_ff, rsp_in;

   assign p7  = $signed(cal.press_b[47:32]);
   assign p8  = $signed(cal.press_b[63:48]);
   assign p9  = $signed(cal.press_c);
   assign p8x = {{16{p8[15]}}, p8};
   assign p9x = {{16{p9[15]}}, p9};

   always_comb begin
      valid_in = {valid_ff[4:0], in_valid};
      p_in     = in_tag.neg ? (64'd0 - in_quo) : in_quo;
      // low 64 bits of (p >> 13)^2 from 32-bit halves
      a13      = $signed(p_ff[0]) >>> 13;
      ll_in    = a13[31:0] * a13[31:0];
      lh_in    = a13[31:0] * a13[63:32];
      pl8_in   = $signed({1'b0, p_ff[0][31:0]}) * p8;
      ph8_in   = p_ff[0][63:32] * p8x;
      aa_in    = ll_ff + {lh_ff[30:0], 33'b0};
      v2s      = {{15{pl8_ff[48]}}, pl8_ff} + {ph8_ff, 32'b0};
      v2_in    = $signed(v2s) >>> 19;
      al9_in   = $signed({1'b0, aa_ff[31:0]}) * p9;
      ah9_in   = aa_ff[63:32] * p9x;
      v1s      = {{15{al9_ff[48]}}, al9_ff} + {ah9_ff, 32'b0};
      v1       = $signed(v1s) >>> 25;
      sum_in   = p_ff[3] + v1 + v2_ff[1];
      prs      = $signed(sum_ff) >>> 8;
      pr       = prs + {{44{p7[15]}}, p7, 4'b0};
      rsp_in.temperature = tag_ff[4].temperature;
      rsp_in.humidity    = tag_ff[4].humidity;
      rsp_in.pressure    = tag_ff[4].zero ? 32'd0 : pr[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= in_tag;
      for (int i = 1; i < 5; i++) begin
         tag_ff[i] <= tag_ff[i-1];
      end
      p_ff[0] <= p_in;
      for (int i = 1; i < 4; i++) begin
         p_ff[i] <= p_ff[i-1];
      end
      ll_ff    <= ll_in;
      lh_ff    <= lh_in;
      pl8_ff   <= pl8_in;
      ph8_ff   <= ph8_in;
      aa_ff    <= aa_in;
      v2_ff[0] <= v2_in;
      v2_ff[1] <= v2_ff[0];
      al9_ff   <= al9_in;
      ah9_ff   <= ah9_in;
      sum_ff   <= sum_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = valid_ff[5];
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

/* hdl/sensor_reading_compensation.sv */
// ----------------------------------------------------------------------------
// sensor_reading_compensation: integer compensation of raw sensor samples
// Temperature, pressure and humidity compensation in one feed-forward pipeline.
// ----------------------------------------------------------------------------
// A request is taken on every cycle with start high; busy never rises, so the
// block takes one sample triple per clock. Each response appears on rsp_data
// with rsp_valid for a single cycle, after the temperature, pressure operand,
// divider and post-divide stages, in request order; the receiver must take it
// then. The pipeline is the 64-stage pressure divider (one quotient bit per
// stage) plus the multiply stages before and after it. Calibration registers
// are written via csr_we/csr_index/csr_wdata and should only change while no
// request is in flight; writes to unused indexes are dropped.
`default_nettype none

module sensor_reading_compensation (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire src_pkg::req_type               req_data,
   output logic                                rsp_valid,
   output src_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [src_pkg::CsrIdxW-1:0]    csr_index,
   input  wire logic [src_pkg::CsrDataW-1:0]   csr_wdata
);
   import src_pkg::*;

   cal_type     cal_ff, cal_in;
   meas_type    meas;
   pdiv_type    pdiv;
   div_tag_type div_tag, quo_tag;
   logic [16:0] humidity;
   logic        quo_valid;
   logic [63:0] quo;

   assign busy = 1'b0;

   always_comb begin
      cal_in = cal_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAL_TEMP:    cal_in.temp    = csr_wdata[47:0];
            CSR_CAL_PRESS_A: cal_in.press_a = csr_wdata;
            CSR_CAL_PRESS_B: cal_in.press_b = csr_wdata;
            CSR_CAL_PRESS_C: cal_in.press_c = csr_wdata[15:0];
            CSR_CAL_HUM:     cal_in.hum     = csr_wdata;
            default:         cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   src_temp u_temp (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_req   (req_data),
      .cal      (cal_ff),
      .meas     (meas)
   );

   src_hum u_hum (
      .clock    (clock),
      .meas     (meas),
      .cal      (cal_ff),
      .humidity (humidity)
   );

   src_pprep u_pprep (
      .clock (clock),
      .reset (reset),
      .meas  (meas),
      .cal   (cal_ff),
      .pdiv  (pdiv)
   );

   assign div_tag.neg         = pdiv.neg;
   assign div_tag.zero        = pdiv.zero;
   assign div_tag.temperature = pdiv.temperature;
   assign div_tag.humidity    = humidity;

   src_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pdiv.valid),
      .in_num    (pdiv.num),
      .in_den    (pdiv.den),
      .in_tag    (div_tag),
      .out_valid (quo_valid),
      .out_quo   (quo),
      .out_tag   (quo_tag)
   );

   src_ppost u_ppost (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (quo_valid),
      .in_quo    (quo),
      .in_tag    (quo_tag),
      .cal       (cal_ff),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

`default_nettype wire

/* hdl/src_checker.sv */
// ----------------------------------------------------------------------------
// src_checker: port-level checks for sensor_reading_compensation
// Watches request acceptance, response timing and humidity range.
// ----------------------------------------------------------------------------
`default_nettype none

module src_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire src_pkg::rsp_type rsp_data
);
   import src_pkg::*;

   // the pipeline never pushes back
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy asserted");

   // every response traces back to a request a fixed depth earlier
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PipeDepth))
      else $error("response without matching request");

   // a request out of reset-free history always yields its response
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && $past(!reset)) |-> ##(PipeDepth) (rsp_valid || $past(reset, 1)
         || $past(reset, PipeDepth - 1)))
      else $error("request lost");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.humidity <= 17'd102400))
      else $error("humidity out of range");

endmodule

bind sensor_reading_compensation src_checker u_src_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
